### sv/md5_byte_stream_hasher_macros.svh
// Assertion macros used by the MD5 hasher checker, md5_chk.
// Plain text; users supply the clock and reset names clock and reset.
`ifndef MD5_BYTE_STREAM_HASHER_MACROS_SVH
`define MD5_BYTE_STREAM_HASHER_MACROS_SVH

// Checked only outside reset.
`define MD5_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define MD5_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### sv/md5_pkg.sv
// MD5 hasher package: sequencer types, round constants and helper functions.
// No dependencies; used by md5_wbuf, md5_round and the top level of the hasher.
package md5_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LOAD,
      ST_ROUND,
      ST_FOLD
   } state_type;

   // What the block in the buffer is when it is compressed.
   typedef enum logic [1:0] {
      KIND_DATA,
      KIND_NOLEN,
      KIND_FINAL
   } kind_type;

   typedef struct packed {
      logic        we;
      logic [3:0]  be;
      logic [3:0]  addr;
      logic [31:0] data;
   } wr_type;

   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hefcdab89;
   localparam logic [31:0] INIT_C = 32'h98badcfe;
   localparam logic [31:0] INIT_D = 32'h10325476;

   localparam logic [7:0] PAD_MARK = 8'h80;

   localparam logic [31:0] K_TABLE [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam logic [4:0] S_TABLE [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   // Message word used by a round.
   function automatic logic [3:0] md5_g(input logic [5:0] idx);
      logic [3:0] g;
      case (idx[5:4])
         2'd0: g = idx[3:0];
         2'd1: g = 4'(idx[3:0] * 4'd5 + 4'd1);
         2'd2: g = 4'(idx[3:0] * 4'd3 + 4'd5);
         default: g = 4'(idx[3:0] * 4'd7);
      endcase
      return g;
   endfunction

   function automatic logic [4:0] md5_s(input logic [5:0] idx);
      return S_TABLE[{idx[5:4], idx[1:0]}];
   endfunction

   function automatic logic [31:0] md5_bswap(input logic [31:0] w);
      return {w[7:0], w[15:8], w[23:16], w[31:24]};
   endfunction

endpackage

### sv/md5_if.sv
// Valid/ready channel interfaces of the MD5 hasher: byte items in, digest items out.
// No dependencies.
interface md5_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       is_last;

   modport source (output valid, data_byte, has_byte, is_last, input ready);
   modport sink (input valid, data_byte, has_byte, is_last, output ready);
endinterface

interface md5_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] digest_first;
   logic [63:0] digest_second;

   modport source (output valid, digest_first, digest_second, input ready);
   modport sink (input valid, digest_first, digest_second, output ready);
endinterface

### sv/md5_wbuf.sv
// 16 x 32-bit block buffer with byte enables and a registered read port.
// Depends on md5_pkg (wr_type).
module md5_wbuf (
   input  logic              clock,
   input  md5_pkg::wr_type   wr,
   input  logic [3:0]        raddr,
   output logic [31:0]       rdata
);

   logic [31:0] mem [16];
   logic [31:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         for (int k = 0; k < 4; k++) begin
            if (wr.be[k]) begin
               mem[wr.addr][8*k +: 8] <= wr.data[8*k +: 8];
            end
         end
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### sv/md5_round.sv
// One MD5 round step: the shared datapath the sequencer runs 64 times a block.
// Depends on md5_pkg (round constants and shift amounts).
module md5_round (
   input  logic [5:0]  idx,
   input  logic [31:0] a,
   input  logic [31:0] b,
   input  logic [31:0] c,
   input  logic [31:0] d,
   input  logic [31:0] w,
   output logic [31:0] b_next
);

   logic [31:0] f;
   logic [31:0] sum;
   logic [31:0] rot;
   logic [4:0]  s;

   always_comb begin
      case (idx[5:4])
         2'd0: f = (b & c) | (~b & d);
         2'd1: f = (d & b) | (~d & c);
         2'd2: f = b ^ c ^ d;
         default: f = c ^ (b | ~d);
      endcase
      sum = a + f + md5_pkg::K_TABLE[idx] + w;
      s   = md5_pkg::md5_s(idx);
      // shift amounts are never zero
      rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
      b_next = b + rot;
   end

endmodule

### sv/md5_byte_stream_hasher.sv
// MD5 hasher top level: byte intake, padding sweep, round sequencer, digest output.
// A byte that does not fill a block is taken while idle; a full block keeps the block
// busy through load, 64 rounds and fold. A last item adds a padding sweep from word
// pos/4 and a block pass, plus a full sweep and a pass when the length does not fit.
// No new byte is taken while a block is busy; the single shared round unit sets the pace.
// Reset (synchronous): chaining words to the MD5 initial values, count to zero, no result.
module md5_byte_stream_hasher (
   input  logic      clock,
   input  logic      reset,
   md5_req_if.sink   req_port,
   md5_rsp_if.source rsp_port
);

   // sequencer
   md5_pkg::state_type state_ff, state_in;
   md5_pkg::kind_type  kind_ff, kind_in;

   // message bookkeeping
   logic [60:0] cnt_ff, cnt_in;       // bytes taken, wraps at 2^61
   logic        last_ff, last_in;     // message ends after this block
   logic        zero_ff, zero_in;     // padding an all-zero length block
   logic [3:0]  word_ff, word_in;     // padding sweep position
   logic [5:0]  round_ff, round_in;

   // chaining and working words
   logic [31:0] chain_ff [4];
   logic [31:0] chain_in [4];
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [31:0] a_in, b_in, c_in, d_in;

   // result register: parts the core from the output handshake
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] dig_first_ff, dig_first_in;
   logic [63:0] dig_second_ff, dig_second_in;

   md5_pkg::wr_type wr;
   md5_pkg::wr_type pad_wr;
   logic [3:0]      raddr;
   logic [31:0]     rdata;
   logic [31:0]     b_next;
   logic [31:0]     sum [4];
   logic [60:0]     cnt_step;
   logic            out_free;
   logic            len_here;

   md5_wbuf u_wbuf (
      .clock (clock),
      .wr    (wr),
      .raddr (raddr),
      .rdata (rdata)
   );

   md5_round u_round (
      .idx    (round_ff),
      .a      (a_ff),
      .b      (b_ff),
      .c      (c_ff),
      .d      (d_ff),
      .w      (rdata),
      .b_next (b_next)
   );

   assign out_free = !rsp_valid_ff || rsp_port.ready;
   assign cnt_step = req_port.has_byte ? cnt_ff + 61'd1 : cnt_ff;
   // length goes in this block unless the marker landed in its last eight bytes
   assign len_here = zero_ff || (cnt_ff[5:3] != 3'b111);

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         sum[k] = chain_ff[k] + ((k == 0) ? a_ff : (k == 1) ? b_ff : (k == 2) ? c_ff : d_ff);
      end
   end

   // Padding word: bytes before the marker are kept, then 0x80, zeros, and the
   // little-endian bit length in the last eight bytes of the length block.
   always_comb begin
      logic [5:0]  p;
      logic [63:0] bit_len;
      bit_len     = {cnt_ff, 3'b000};
      pad_wr.we   = 1'b1;
      pad_wr.addr = word_ff;
      pad_wr.be   = 4'b0000;
      pad_wr.data = '0;
      for (int k = 0; k < 4; k++) begin
         p = {word_ff, k[1:0]};
         pad_wr.be[k] = zero_ff || (p >= cnt_ff[5:0]);
         if (!zero_ff && p == cnt_ff[5:0]) begin
            pad_wr.data[8*k +: 8] = md5_pkg::PAD_MARK;
         end else if (len_here && p[5:3] == 3'b111) begin
            pad_wr.data[8*k +: 8] = bit_len[{p[2:0], 3'b000} +: 8];
         end else begin
            pad_wr.data[8*k +: 8] = 8'h00;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         md5_pkg::ST_IDLE: begin
            if (req_port.valid) begin
               if (req_port.has_byte && cnt_ff[5:0] == 6'h3f) begin
                  state_in = md5_pkg::ST_LOAD;
               end else if (req_port.is_last) begin
                  state_in = md5_pkg::ST_PAD;
               end
            end
         end
         md5_pkg::ST_PAD: begin
            if (word_ff == 4'hf) begin
               state_in = md5_pkg::ST_LOAD;
            end
         end
         md5_pkg::ST_LOAD: state_in = md5_pkg::ST_ROUND;
         md5_pkg::ST_ROUND: begin
            if (round_ff == 6'h3f) begin
               state_in = md5_pkg::ST_FOLD;
            end
         end
         md5_pkg::ST_FOLD: begin
            case (kind_ff)
               md5_pkg::KIND_FINAL: begin
                  if (out_free) begin
                     state_in = md5_pkg::ST_IDLE;
                  end
               end
               md5_pkg::KIND_NOLEN: state_in = md5_pkg::ST_PAD;
               default: state_in = last_ff ? md5_pkg::ST_PAD : md5_pkg::ST_IDLE;
            endcase
         end
         default: state_in = md5_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      kind_in       = kind_ff;
      cnt_in        = cnt_ff;
      last_in       = last_ff;
      zero_in       = zero_ff;
      word_in       = word_ff;
      round_in      = round_ff;
      chain_in      = chain_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      c_in          = c_ff;
      d_in          = d_ff;
      dig_first_in  = dig_first_ff;
      dig_second_in = dig_second_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_port.ready;
      req_port.ready = 1'b0;
      wr            = '0;
      raddr         = 4'd0;

      case (state_ff)
         md5_pkg::ST_IDLE: begin
            req_port.ready = 1'b1;
            if (req_port.valid) begin
               wr.we   = req_port.has_byte;
               wr.be   = 4'b0001 << cnt_ff[1:0];
               wr.addr = cnt_ff[5:2];
               wr.data = {4{req_port.data_byte}};
               cnt_in  = cnt_step;
               last_in = req_port.is_last;
               kind_in = md5_pkg::KIND_DATA;
               zero_in = 1'b0;
               word_in = cnt_step[5:2];
            end
         end
         md5_pkg::ST_PAD: begin
            wr      = pad_wr;
            word_in = word_ff + 4'd1;
            if (word_ff == 4'hf) begin
               kind_in = len_here ? md5_pkg::KIND_FINAL : md5_pkg::KIND_NOLEN;
            end
         end
         md5_pkg::ST_LOAD: begin
            a_in     = chain_ff[0];
            b_in     = chain_ff[1];
            c_in     = chain_ff[2];
            d_in     = chain_ff[3];
            round_in = 6'd0;
            raddr    = md5_pkg::md5_g(6'd0);
         end
         md5_pkg::ST_ROUND: begin
            a_in     = d_ff;
            b_in     = b_next;
            c_in     = b_ff;
            d_in     = c_ff;
            round_in = round_ff + 6'd1;
            raddr    = md5_pkg::md5_g(round_ff + 6'd1);
         end
         md5_pkg::ST_FOLD: begin
            case (kind_ff)
               md5_pkg::KIND_FINAL: begin
                  // hold here until the result register is free
                  if (out_free) begin
                     rsp_valid_in  = 1'b1;
                     dig_first_in  = {md5_pkg::md5_bswap(sum[0]),
                                      md5_pkg::md5_bswap(sum[1])};
                     dig_second_in = {md5_pkg::md5_bswap(sum[2]),
                                      md5_pkg::md5_bswap(sum[3])};
                     chain_in[0]   = md5_pkg::INIT_A;
                     chain_in[1]   = md5_pkg::INIT_B;
                     chain_in[2]   = md5_pkg::INIT_C;
                     chain_in[3]   = md5_pkg::INIT_D;
                     cnt_in        = '0;
                     last_in       = 1'b0;
                  end
               end
               md5_pkg::KIND_NOLEN: begin
                  chain_in = sum;
                  zero_in  = 1'b1;
                  word_in  = 4'd0;
               end
               default: begin
                  chain_in = sum;
                  zero_in  = 1'b0;
                  word_in  = 4'd0;
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= md5_pkg::ST_IDLE;
         kind_ff      <= md5_pkg::KIND_DATA;
         cnt_ff       <= '0;
         last_ff      <= 1'b0;
         zero_ff      <= 1'b0;
         word_ff      <= '0;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         chain_ff[0]  <= md5_pkg::INIT_A;
         chain_ff[1]  <= md5_pkg::INIT_B;
         chain_ff[2]  <= md5_pkg::INIT_C;
         chain_ff[3]  <= md5_pkg::INIT_D;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         cnt_ff       <= cnt_in;
         last_ff      <= last_in;
         zero_ff      <= zero_in;
         word_ff      <= word_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
         chain_ff     <= chain_in;
      end
   end

   // working words and result payload need no reset
   always_ff @(posedge clock) begin
      a_ff          <= a_in;
      b_ff          <= b_in;
      c_ff          <= c_in;
      d_ff          <= d_in;
      dig_first_ff  <= dig_first_in;
      dig_second_ff <= dig_second_in;
   end

   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.digest_first  = dig_first_ff;
   assign rsp_port.digest_second = dig_second_ff;

endmodule

### sv/md5_chk.sv
// Port-level checker for the MD5 hasher, bound to the top level.
// Depends on md5_byte_stream_hasher_macros.svh and md5_byte_stream_hasher.
`include "md5_byte_stream_hasher_macros.svh"

module md5_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_last,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_first,
   input logic [63:0] rsp_second
);

   `MD5_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "result item dropped while stalled")
   `MD5_ASSERT(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(rsp_first) && $stable(rsp_second), "stalled digest changed")
   `MD5_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_valid, "result item out of reset")
   `MD5_ASSERT(a_last_busy, req_valid && req_ready && req_last |=> !req_ready, "item taken during padding")

endmodule

bind md5_byte_stream_hasher md5_chk u_md5_chk (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_port.valid),
   .req_ready  (req_port.ready),
   .req_last   (req_port.is_last),
   .rsp_valid  (rsp_port.valid),
   .rsp_ready  (rsp_port.ready),
   .rsp_first  (rsp_port.digest_first),
   .rsp_second (rsp_port.digest_second)
);

### tb/tb_top.sv
// Self-checking bench for md5_byte_stream_hasher: byte items in, one digest item per message.
// Needs md5_if.sv (request and digest channel interfaces) and the hasher RTL; no package
// items are used, the digest predictor below is standalone.

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // Run limit for the whole run of this stimulus.
   localparam int RUN_LIMIT_NS   = 2_000_000;
   // Receiver hold-off used to back the hasher up into its input.
   localparam int RSP_HOLD_CYCLES = 400;
   // Worst tail after the last digest: two padding sweeps and two block passes.
   localparam int TAIL_CYCLES     = 200;

   // Per-round additive constants and left rotations of the MD5 compression function.
   localparam logic [31:0] ROUND_ADD [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam int ROUND_ROT [16] = '{
      7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
   };

   localparam logic [31:0] CHAIN_START [4] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
   };

   localparam logic [7:0] PAD_BYTE = 8'h80;

   // Lengths that put the pad byte and the length field either side of a block edge.
   localparam int EDGE_LENGTHS [6] = '{55, 56, 57, 63, 64, 65};

   typedef struct packed {
      logic [63:0] first;
      logic [63:0] second;
   } digest_type;

   logic clock = 1'b0;
   logic reset;

   md5_req_if req_ch ();
   md5_rsp_if rsp_ch ();

   md5_byte_stream_hasher u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Digest predictor: its own chaining words, block store and running length.
   // ---------------------------------------------------------------------------
   logic [31:0] hash_state [4];
   logic [7:0]  msg_block  [64];
   logic [60:0] msg_len;

   digest_type pending_digests [$];

   int mismatch_count = 0;
   int counted_items  = 0;   // items that carry a byte or close a message
   int messages_sent  = 0;

   // Idle percentages of each side; the receiver's is read in its own process.
   int src_idle_pct = 0;
   int snk_idle_pct = 0;
   int hold_asks    = 0;     // bumped by a test to start one long receiver hold-off

   function automatic logic [31:0] rotl32(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   // Word in printed order: least significant byte first.
   function automatic logic [31:0] le_bytes(input logic [31:0] w);
      return {w[7:0], w[15:8], w[23:16], w[31:24]};
   endfunction

   function automatic void restart_chain();
      for (int i = 0; i < 4; i++)
         hash_state[i] = CHAIN_START[i];
      msg_len = '0;
   endfunction

   // 64 rounds over msg_block, added into the chaining words.
   function automatic void fold_block();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, f, t;
      int g;
      for (int i = 0; i < 16; i++)
         w[i] = {msg_block[4*i+3], msg_block[4*i+2], msg_block[4*i+1], msg_block[4*i]};
      a = hash_state[0];
      b = hash_state[1];
      c = hash_state[2];
      d = hash_state[3];
      for (int r = 0; r < 64; r++) begin
         case (r / 16)
            0: begin
               f = (b & c) | (~b & d);
               g = r;
            end
            1: begin
               f = (d & b) | (~d & c);
               g = (5 * r + 1) % 16;
            end
            2: begin
               f = b ^ c ^ d;
               g = (3 * r + 5) % 16;
            end
            default: begin
               f = c ^ (b | ~d);
               g = (7 * r) % 16;
            end
         endcase
         t = d;
         d = c;
         c = b;
         b = b + rotl32(a + f + ROUND_ADD[r] + w[g], ROUND_ROT[(r / 16) * 4 + r % 4]);
         a = t;
      end
      hash_state[0] = hash_state[0] + a;
      hash_state[1] = hash_state[1] + b;
      hash_state[2] = hash_state[2] + c;
      hash_state[3] = hash_state[3] + d;
   endfunction

   // Takes one accepted item; on a closing item pads, finishes and queues the digest.
   function automatic void absorb_item(input logic [7:0] data, input logic has,
                                       input logic last);
      int pos;
      logic [63:0] bit_len;
      digest_type dg;
      if (has) begin
         msg_block[msg_len[5:0]] = data;
         msg_len = msg_len + 61'd1;
         if (msg_len[5:0] == 6'd0)
            fold_block();
      end
      if (!last)
         return;
      pos = int'(msg_len[5:0]);
      msg_block[pos] = PAD_BYTE;
      for (int i = pos + 1; i < 64; i++)
         msg_block[i] = 8'h00;
      // no room left for the length field: close this block, length goes in a fresh one
      if (pos >= 56) begin
         fold_block();
         for (int i = 0; i < 64; i++)
            msg_block[i] = 8'h00;
      end
      bit_len = {msg_len, 3'b000};
      for (int i = 0; i < 8; i++)
         msg_block[56 + i] = bit_len[8*i +: 8];
      fold_block();
      dg.first  = {le_bytes(hash_state[0]), le_bytes(hash_state[1])};
      dg.second = {le_bytes(hash_state[2]), le_bytes(hash_state[3])};
      pending_digests = {pending_digests, dg};
      restart_chain();
   endfunction

   // ---------------------------------------------------------------------------
   // Mismatch reporting and the digest checker (sampled at the rising edge).
   // ---------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   digest_type want_dg;

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_digests.size() == 0) begin
            report_mismatch("digest item with none expected", rsp_ch.digest_first, '0);
         end else begin
            want_dg = pending_digests.pop_front();
            if (rsp_ch.digest_first !== want_dg.first)
               report_mismatch("digest_first", rsp_ch.digest_first, want_dg.first);
            if (rsp_ch.digest_second !== want_dg.second)
               report_mismatch("digest_second", rsp_ch.digest_second, want_dg.second);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Receiver: random ready at the falling edge, plus one long hold-off on request.
   // The hold-off is counted here so only this process drives ready.
   // ---------------------------------------------------------------------------
   initial begin : rsp_ready_drive
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = RSP_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Sender. Entered just after a falling edge; returns just after the falling edge
   // that follows acceptance, with valid still high. The next call, or req_quiet(),
   // then sets valid in that same step, so valid sees one assignment per step.
   // ---------------------------------------------------------------------------
   task automatic send_item(input logic [7:0] data, input logic has, input logic last);
      while ($urandom_range(99) < src_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= data;
      req_ch.has_byte  <= has;
      req_ch.is_last   <= last;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      absorb_item(data, has, last);
      if (has || last)
         counted_items++;
      @(negedge clock);
   endtask

   task automatic req_quiet();
      req_ch.valid <= 1'b0;
      @(negedge clock);
   endtask

   // Sender pauses until every expected digest has come back.
   task automatic wait_drained();
      req_quiet();
      while (pending_digests.size() != 0)
         @(negedge clock);
   endtask

   // One message of random bytes, with the odd ignored empty item mixed in; the
   // closing item either carries the last byte or is an empty closing item.
   task automatic send_message(input int n_bytes, input bit byte_on_last);
      for (int i = 0; i < n_bytes; i++) begin
         if ($urandom_range(99) < 6)
            send_item(8'($urandom), 1'b0, 1'b0);
         send_item(8'($urandom), 1'b1, byte_on_last && (i == n_bytes - 1));
      end
      if (n_bytes == 0 || !byte_on_last)
         send_item(8'($urandom), 1'b0, 1'b1);
      messages_sent++;
   endtask

   // Mostly short messages; a fair share around one or two block edges; few long ones.
   function automatic int pick_length();
      int roll;
      roll = int'($urandom_range(99));
      if (roll < 55)
         return int'($urandom_range(0, 16));
      else if (roll < 72)
         return int'($urandom_range(17, 54));
      else if (roll < 90)
         return 64 * int'($urandom_range(0, 1)) + EDGE_LENGTHS[$urandom_range(0, 5)];
      else if (roll < 98)
         return int'($urandom_range(66, 130));
      return int'($urandom_range(131, 260));
   endfunction

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Empty message straight after reset, after ignored items, and back to back.
   task automatic test_empty_messages();
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'hff, 1'b0, 1'b0);
      send_item(8'h5a, 1'b0, 1'b0);
      send_item(8'hff, 1'b0, 1'b1);
      send_item(8'h00, 1'b0, 1'b1);
      wait_drained();
   endtask

   // One-byte messages (0x00, 0xff, 0x55), byte on the closing item or before it.
   task automatic test_single_bytes();
      send_item(8'h00, 1'b1, 1'b1);
      send_item(8'hff, 1'b1, 1'b1);
      send_item(8'h55, 1'b1, 1'b0);
      send_item(8'haa, 1'b0, 1'b1);
      wait_drained();
   endtask

   // "abc", then "abc" again closed by an empty item with an ignored item in between.
   task automatic test_short_text();
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b0);
      send_item(8'h63, 1'b1, 1'b0);
      send_item(8'h80, 1'b0, 1'b1);
      wait_drained();
   endtask

   // Lengths where the length field just fits, just misses, and a block closes exactly.
   task automatic test_block_edges();
      for (int i = 0; i < 6; i++)
         send_message(EDGE_LENGTHS[i], 1'($urandom_range(0, 1)));
      wait_drained();
   endtask

   task automatic test_random_traffic(input int src_pct, input int snk_pct);
      int first_items;
      int first_msgs;
      src_idle_pct = src_pct;
      snk_idle_pct = snk_pct;
      first_items  = counted_items;
      first_msgs   = messages_sent;
      while (counted_items - first_items < 200 || messages_sent - first_msgs < 4)
         send_message(pick_length(), 1'($urandom_range(0, 1)));
      wait_drained();
   endtask

   // Receiver holds off for a long stretch while the sender keeps offering messages,
   // so a digest sits unread and the hasher has to stall its input.
   task automatic test_output_backpressure();
      src_idle_pct = 0;
      snk_idle_pct = 0;
      req_quiet();
      @(posedge clock);
      hold_asks++;
      @(negedge clock);
      for (int m = 0; m < 6; m++)
         send_message(int'($urandom_range(3, 12)), 1'($urandom_range(0, 1)));
      wait_drained();
   endtask

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin : run_tests
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.data_byte  = 8'h00;
      req_ch.has_byte   = 1'b0;
      req_ch.is_last    = 1'b0;
      restart_chain();
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // first phase of idling: sender 31 %, receiver 50 %
      src_idle_pct = 31;
      snk_idle_pct = 50;
      test_empty_messages();
      test_single_bytes();
      test_short_text();
      test_block_edges();
      test_random_traffic(31, 50);
      test_random_traffic(50, 31);
      test_output_backpressure();
      test_random_traffic(0, 0);

      // nothing outstanding; let any stray digest show itself before deciding
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // Watchdog: a hung handshake or a digest that never comes ends here.
   initial begin : run_limit
      #(RUN_LIMIT_NS);
      $display("TB_ERROR");
      $finish;
   end

endmodule

### md5_byte_stream_hasher.f
+incdir+sv
sv/md5_pkg.sv
sv/md5_if.sv
sv/md5_wbuf.sv
sv/md5_round.sv
sv/md5_byte_stream_hasher.sv
sv/md5_chk.sv
tb/tb_top.sv
